// ===== rtl/core/fsup_pkg.sv =====
// ---------------------------------------------------------------------------
// fsup_pkg: shared definitions for the fault storm suppressor
// Table size, field codes, search word and update broadcast types.
// ---------------------------------------------------------------------------
package fsup_pkg;

    // table geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // field widths
    localparam int RID_W = 16;
    localparam int CNT_W = 4;
    localparam int OIX_W = 5;
    localparam int OC_W  = 3;

    localparam logic [CNT_W-1:0] CNT_MAX     = 4'hf;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 4'd8;
    localparam logic [OIX_W-1:0] IDX_NONE    = OIX_W'(ENTRIES);

    // input kinds
    localparam logic FUNC_FAULT = 1'b0;
    localparam logic FUNC_BATCH = 1'b1;

    // result outcome codes
    typedef enum logic [OC_W-1:0] {
        OC_HIT     = 3'd0,
        OC_NEW     = 3'd1,
        OC_FULL    = 3'd2,
        OC_IGNORED = 3'd3,
        OC_BATCH   = 3'd4
    } outcome_t;

    // control sequence
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_WALK = 2'd1,
        S_DONE = 2'd2
    } state_t;

    // search word handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [RID_W-1:0] rid;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [CNT_W-1:0] hit_cnt;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } tok_t;

    // update broadcast to all cells
    typedef struct packed {
        logic             wr;
        logic             claim;
        logic             batch;
        logic             disabled;
        logic [IDX_W-1:0] idx;
        logic [RID_W-1:0] rid;
        logic [CNT_W-1:0] cnt;
    } upd_t;

    // table index widened or cut to the result field
    function automatic logic [OIX_W-1:0] idx_out(input logic [IDX_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[OIX_W-1:0];
    endfunction

endpackage

// ===== rtl/core/fault_storm_suppressor.sv =====
// ---------------------------------------------------------------------------
// fault_storm_suppressor: DMA remapping fault storm suppressor
// Requester table built as a row of entry cells with a search word walking
// through it; one result word per input word.
// ---------------------------------------------------------------------------
// Use:
//   Input channel (in_valid/in_stall) carries func and requester_id; the
//   output channel (out_valid/out_stall) carries entry_index, entry_count,
//   outcome and mask_reporting. A word is taken when valid is high and stall
//   is low. fault_limit sits at APB address 0.
// Timing:
//   A fault word walks the cell row, one cell a cycle; its result is
//   registered at the end of the row and then loaded into the output
//   register once that is free, and only then is the next word taken.
//   Batch-end words and faults ignored while disabled skip the walk.
//   One word is in work at a time; in_stall is high while it is.
// Reset:
//   All counts and changed marks clear, the batch is enabled and
//   fault_limit returns to 8. No clearing pass is needed.
// Stall:
//   A finished result stays in the output register while out_stall is high;
//   the next input word is still taken and waits before its update until
//   the output register is free.
// ---------------------------------------------------------------------------
module fault_storm_suppressor (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [fsup_pkg::RID_W-1:0]    requester_id,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fsup_pkg::OIX_W-1:0]    entry_index,
    output logic [fsup_pkg::CNT_W-1:0]    entry_count,
    output logic [fsup_pkg::OC_W-1:0]     outcome,
    output logic                          mask_reporting,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    fsup_pkg::state_t           state_reg;
    fsup_pkg::state_t           state_next;
    logic                       func_reg;
    logic [fsup_pkg::RID_W-1:0] rid_reg;
    logic                       disabled_reg;
    logic                       disabled_next;
    logic [fsup_pkg::CNT_W-1:0] limit_reg;
    fsup_pkg::tok_t             res_tok_reg;
    fsup_pkg::tok_t             tok [fsup_pkg::ENTRIES+1];
    logic [fsup_pkg::ENTRIES-1:0] tok_valids;
    fsup_pkg::upd_t             upd;

    logic                       out_valid_reg;
    logic [fsup_pkg::OIX_W-1:0] oix_reg;
    logic [fsup_pkg::CNT_W-1:0] ocnt_reg;
    fsup_pkg::outcome_t         oc_reg;
    logic                       omask_reg;
    logic [fsup_pkg::OIX_W-1:0] oix_next;
    logic [fsup_pkg::CNT_W-1:0] ocnt_next;
    fsup_pkg::outcome_t         oc_next;
    logic                       omask_next;

    logic                       in_take;
    logic                       out_free;
    logic                       load;
    logic                       cfg_wr;
    logic [fsup_pkg::CNT_W-1:0] new_cnt;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= fsup_pkg::LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            limit_reg <= pwdata[fsup_pkg::CNT_W-1:0];
        end
    end

    // handshake
    assign in_stall = (state_reg != fsup_pkg::S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // search word launched into the first cell
    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = in_take && (func == fsup_pkg::FUNC_FAULT) && !disabled_reg;
        tok[0].rid   = requester_id;
    end

    // cell row
    for (genvar i = 0; i < fsup_pkg::ENTRIES; i++)
    begin : g_cell
        fsup_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (fsup_pkg::IDX_W'(i)),
            .tok_in   (tok[i]),
            .upd      (upd),
            .tok_out  (tok[i+1])
        );
        assign tok_valids[i] = tok[i+1].valid;
    end

    // sequencer and result / update generation
    always_comb
    begin
        state_next    = state_reg;
        disabled_next = disabled_reg;
        load          = 1'b0;
        upd           = '0;
        upd.rid       = rid_reg;
        upd.disabled  = disabled_reg;
        oix_next      = fsup_pkg::IDX_NONE;
        ocnt_next     = '0;
        oc_next       = fsup_pkg::OC_IGNORED;
        omask_next    = 1'b0;
        new_cnt       = (res_tok_reg.hit_cnt == fsup_pkg::CNT_MAX) ?
                        res_tok_reg.hit_cnt : res_tok_reg.hit_cnt + 4'd1;
        case (state_reg)
            fsup_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    if ((func == fsup_pkg::FUNC_FAULT) && !disabled_reg)
                    begin
                        state_next = fsup_pkg::S_WALK;
                    end
                    else
                    begin
                        state_next = fsup_pkg::S_DONE;
                    end
                end
            end
            fsup_pkg::S_WALK:
            begin
                if (tok[fsup_pkg::ENTRIES].valid)
                begin
                    state_next = fsup_pkg::S_DONE;
                end
            end
            fsup_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = fsup_pkg::S_IDLE;
                    if (func_reg == fsup_pkg::FUNC_BATCH)
                    begin
                        upd.batch     = 1'b1;
                        oc_next       = fsup_pkg::OC_BATCH;
                        disabled_next = 1'b0;
                    end
                    else if (disabled_reg)
                    begin
                        oc_next = fsup_pkg::OC_IGNORED;
                    end
                    else if (res_tok_reg.hit)
                    begin
                        upd.wr     = 1'b1;
                        upd.idx    = res_tok_reg.hit_idx;
                        upd.cnt    = new_cnt;
                        oix_next   = fsup_pkg::idx_out(res_tok_reg.hit_idx);
                        ocnt_next  = new_cnt;
                        oc_next    = fsup_pkg::OC_HIT;
                        omask_next = (new_cnt > limit_reg);
                    end
                    else if (res_tok_reg.free)
                    begin
                        upd.wr     = 1'b1;
                        upd.claim  = 1'b1;
                        upd.idx    = res_tok_reg.free_idx;
                        upd.cnt    = 4'd1;
                        oix_next   = fsup_pkg::idx_out(res_tok_reg.free_idx);
                        ocnt_next  = 4'd1;
                        oc_next    = fsup_pkg::OC_NEW;
                        omask_next = (4'd1 > limit_reg);
                    end
                    else
                    begin
                        oc_next    = fsup_pkg::OC_FULL;
                        omask_next = 1'b1;
                    end
                    if (omask_next)
                    begin
                        disabled_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = fsup_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fsup_pkg::S_IDLE;
            disabled_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            disabled_reg <= disabled_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= func;
            rid_reg  <= requester_id;
        end
        if (tok[fsup_pkg::ENTRIES].valid)
        begin
            res_tok_reg <= tok[fsup_pkg::ENTRIES];
        end
        if (load)
        begin
            oix_reg   <= oix_next;
            ocnt_reg  <= ocnt_next;
            oc_reg    <= oc_next;
            omask_reg <= omask_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign entry_index    = oix_reg;
    assign entry_count    = ocnt_reg;
    assign outcome        = oc_reg;
    assign mask_reporting = omask_reg;

    // only one search word in the cell row at a time
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valids))
        else $error("more than one search word in flight");

    // search word leaves the row only while the sequencer waits for it
    a_tok_walk: assert property (@(posedge clk) disable iff (!rst_n)
        tok[fsup_pkg::ENTRIES].valid |-> (state_reg == fsup_pkg::S_WALK))
        else $error("search word finished outside the walk");

    // a masking result leaves the batch disabled
    a_mask_dis: assert property (@(posedge clk) disable iff (!rst_n)
        load && omask_next |=> disabled_reg)
        else $error("mask without batch disable");

    // a batch close re-enables the batch
    a_batch_en: assert property (@(posedge clk) disable iff (!rst_n)
        load && (func_reg == fsup_pkg::FUNC_BATCH) |=> !disabled_reg)
        else $error("batch close left the batch disabled");

    // a loaded result is never overwritten while stalled
    a_no_ovr: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten under stall");

endmodule

// ===== rtl/core/fsup_cell.sv =====
// ---------------------------------------------------------------------------
// fsup_cell: one table entry of the fault storm suppressor
// Holds requester, count and changed mark; looks at the passing search word
// and hands it to the next cell through a register.
// ---------------------------------------------------------------------------
module fsup_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [fsup_pkg::IDX_W-1:0] cell_idx,
    input  fsup_pkg::tok_t            tok_in,
    input  fsup_pkg::upd_t            upd,
    output fsup_pkg::tok_t            tok_out
);

    logic [fsup_pkg::RID_W-1:0] req_reg;
    logic [fsup_pkg::RID_W-1:0] req_next;
    logic [fsup_pkg::CNT_W-1:0] count_reg;
    logic [fsup_pkg::CNT_W-1:0] count_next;
    logic                       changed_reg;
    logic                       changed_next;
    fsup_pkg::tok_t             tok_reg;
    fsup_pkg::tok_t             tok_next;
    logic                       live;
    logic                       match;
    logic                       sel;

    // search step: first live match, first free entry
    always_comb
    begin
        live     = (count_reg != '0);
        match    = live && (req_reg == tok_in.rid);
        tok_next = tok_in;
        if (!tok_in.hit && match)
        begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = cell_idx;
            tok_next.hit_cnt = count_reg;
        end
        if (!tok_in.free && !live)
        begin
            tok_next.free     = 1'b1;
            tok_next.free_idx = cell_idx;
        end
    end

    // entry update from the broadcast
    always_comb
    begin
        sel          = upd.wr && (upd.idx == cell_idx);
        count_next   = count_reg;
        changed_next = changed_reg;
        req_next     = req_reg;
        if (upd.batch)
        begin
            if (upd.disabled || !changed_reg)
            begin
                count_next = '0;
            end
            changed_next = 1'b0;
        end
        else if (sel)
        begin
            count_next   = upd.cnt;
            changed_next = 1'b1;
        end
        if (sel && upd.claim)
        begin
            req_next = upd.rid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            changed_reg <= 1'b0;
            tok_reg     <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            changed_reg <= changed_next;
            tok_reg     <= tok_next;
        end
    end

    // requester id: only read while the count is nonzero
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    assign tok_out = tok_reg;

endmodule
